FILE: rtl/som_pkg.sv
// ----------------------------------------------------------------------------
// som_pkg
// Shared constants and the weight update function of the map search and update unit.
// ----------------------------------------------------------------------------
package som_pkg;

    localparam int NumFeatures = 4;
    localparam int FeatW       = 16;
    localparam int WordW       = NumFeatures * FeatW;
    localparam int DistW       = 34;
    localparam int LabelW      = 2;
    localparam int ModeW       = 2;
    localparam int CoordW      = 4;
    localparam int RadiusW     = 4;

    localparam logic [ModeW-1:0] MODE_TRAIN = 2'd0;
    localparam logic [ModeW-1:0] MODE_LOAD  = 2'd1;
    localparam logic [ModeW-1:0] MODE_READ  = 2'd2;

    // Moves one weight towards the sample by alpha*(v-w), floored.
    function automatic logic [FeatW-1:0] move_toward(
        input logic [FeatW-1:0] w,
        input logic [FeatW-1:0] v,
        input logic [FeatW-1:0] alpha
    );
        logic [FeatW-1:0]   diff;
        logic [2*FeatW-1:0] prod;
        logic [FeatW:0]     step;
        logic [FeatW+1:0]   res;
        if (v >= w) begin
            diff = v - w;
            prod = alpha * diff;
            step = {1'b0, prod[2*FeatW-1:FeatW]};
            res  = {2'b00, w} + {1'b0, step};
            if (res[FeatW+1:FeatW] != 2'b00) begin
                move_toward = {FeatW{1'b1}};
            end
            else begin
                move_toward = res[FeatW-1:0];
            end
        end
        else begin
            diff = w - v;
            prod = alpha * diff;
            step = {1'b0, prod[2*FeatW-1:FeatW]} + {{FeatW{1'b0}}, (prod[FeatW-1:0] != '0)};
            res  = {2'b00, w} - {1'b0, step};
            if (res[FeatW+1]) begin
                move_toward = '0;
            end
            else begin
                move_toward = res[FeatW-1:0];
            end
        end
    endfunction

endpackage

FILE: rtl/som_ram.sv
// ----------------------------------------------------------------------------
// som_ram
// Generic single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module som_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One access per cycle; read data appears in the cycle after the address.
    always_ff @(posedge clk)
    begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

FILE: rtl/som_bmu_search_and_update_unit.sv
// ----------------------------------------------------------------------------
// som_bmu_search_and_update_unit
// One Kohonen map training step, plus load and read access to the neurons.
// ----------------------------------------------------------------------------
// A train transaction scans every neuron once, one weight memory read a
// cycle, then rewrites the clipped window around the winner through the
// same single port, reading each neuron in S_UPRD and writing it back in
// S_UPWR. After reset the label memory is cleared one entry a cycle, and
// no transaction is accepted until the clearing is done. The result is
// held in an output register until it is taken; the next transaction is
// worked on meanwhile and only waits in S_OUT if the previous result has
// still not been taken.
// ----------------------------------------------------------------------------
module som_bmu_search_and_update_unit #(
    parameter int GRID_COLS = 16,
    parameter int GRID_ROWS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [som_pkg::ModeW-1:0]     mode,
    input  logic [som_pkg::FeatW-1:0]     feature_0,
    input  logic [som_pkg::FeatW-1:0]     feature_1,
    input  logic [som_pkg::FeatW-1:0]     feature_2,
    input  logic [som_pkg::FeatW-1:0]     feature_3,
    input  logic [som_pkg::FeatW-1:0]     learn_rate,
    input  logic [som_pkg::RadiusW-1:0]   radius,
    input  logic [som_pkg::LabelW-1:0]    class_label,
    input  logic [som_pkg::CoordW-1:0]    cell_col,
    input  logic [som_pkg::CoordW-1:0]    cell_row,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [som_pkg::CoordW-1:0]    win_col,
    output logic [som_pkg::CoordW-1:0]    win_row,
    output logic [som_pkg::DistW-1:0]     win_distance,
    output logic [som_pkg::LabelW-1:0]    cell_label,
    output logic [som_pkg::FeatW-1:0]     weight_0,
    output logic [som_pkg::FeatW-1:0]     weight_1,
    output logic [som_pkg::FeatW-1:0]     weight_2,
    output logic [som_pkg::FeatW-1:0]     weight_3
);

    import som_pkg::*;

    localparam int Cells = GRID_COLS * GRID_ROWS;
    localparam int AddrW = (Cells > 1) ? $clog2(Cells) : 1;
    localparam int ColW  = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
    localparam int RowW  = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
    localparam int CW    = ColW + 1;
    localparam int RW    = RowW + 1;
    localparam logic [CW-1:0] LastCol = CW'(GRID_COLS - 1);
    localparam logic [RW-1:0] LastRow = RW'(GRID_ROWS - 1);
    localparam logic [AddrW:0] LastCell = (AddrW+1)'(Cells - 1);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_ACC, S_SCAN, S_LAST, S_UPRD, S_UPWR, S_RDWAIT, S_RDOUT, S_OUT
    } state_t;

    state_t state_reg;

    // Captured transaction.
    logic [ModeW-1:0]   mode_reg;
    logic [FeatW-1:0]   v_reg [NumFeatures];
    logic [FeatW-1:0]   alpha_reg;
    logic [RadiusW-1:0] radius_reg;
    logic [LabelW-1:0]  label_reg;
    logic [CoordW-1:0]  ccol_reg;
    logic [CoordW-1:0]  crow_reg;

    // Scan and window walk.
    logic [CW-1:0]      col_reg;
    logic [RW-1:0]      row_reg;
    logic [CW-1:0]      rcol_reg;   // coordinates of the word in read data
    logic [RW-1:0]      rrow_reg;
    logic               first_reg;
    logic [DistW-1:0]   best_reg;
    logic [CW-1:0]      bc_reg;
    logic [RW-1:0]      br_reg;
    logic [CW-1:0]      c1_reg;
    logic [RW-1:0]      r0_reg, r1_reg;
    logic [AddrW:0]     clr_reg;

    // Result being built for the current transaction.
    logic [CoordW-1:0]  res_col_reg, res_row_reg;
    logic [DistW-1:0]   res_dist_reg;
    logic [LabelW-1:0]  res_lab_reg;
    logic [WordW-1:0]   res_w_reg;

    // Output register.
    logic               ov_reg;
    logic [CoordW-1:0]  ocol_reg, orow_reg;
    logic [DistW-1:0]   odist_reg;
    logic [LabelW-1:0]  olab_reg;
    logic [WordW-1:0]   ow_reg;

    // Memory ports.
    logic             w_we, l_we;
    logic [AddrW-1:0] w_addr, l_addr;
    logic [WordW-1:0] w_wdata, w_rdata;
    logic [LabelW-1:0] l_wdata, l_rdata;

    som_ram #(.WIDTH(WordW), .DEPTH(Cells)) u_weights (
        .clk(clk), .we(w_we), .addr(w_addr), .wdata(w_wdata), .rdata(w_rdata)
    );
    som_ram #(.WIDTH(LabelW), .DEPTH(Cells)) u_labels (
        .clk(clk), .we(l_we), .addr(l_addr), .wdata(l_wdata), .rdata(l_rdata)
    );

    function automatic logic [AddrW-1:0] cell_addr(input logic [CW-1:0] c,
                                                   input logic [RW-1:0] r);
        logic [AddrW+CW+RW:0] a;
        a = (AddrW+CW+RW+1)'(c) * (AddrW+CW+RW+1)'(GRID_ROWS) + (AddrW+CW+RW+1)'(r);
        cell_addr = a[AddrW-1:0];
    endfunction

    // Distance of the word in read data to the sample.
    logic [DistW-1:0] cur_dist;
    always_comb
    begin
        logic [FeatW-1:0] w, d;
        logic [2*FeatW-1:0] sq;
        cur_dist = '0;
        for (int k = 0; k < NumFeatures; k++) begin
            w = w_rdata[k*FeatW +: FeatW];
            d = (w > v_reg[k]) ? (w - v_reg[k]) : (v_reg[k] - w);
            sq = d * d;
            cur_dist = cur_dist + DistW'(sq);
        end
    end

    // Updated word.
    logic [WordW-1:0] moved;
    always_comb
    begin
        for (int k = 0; k < NumFeatures; k++) begin
            moved[k*FeatW +: FeatW] = move_toward(w_rdata[k*FeatW +: FeatW], v_reg[k],
                                                  alpha_reg);
        end
    end

    logic cell_in_grid;
    assign cell_in_grid = (int'(ccol_reg) < GRID_COLS) && (int'(crow_reg) < GRID_ROWS);

    logic [CW-1:0] ccol_ext;
    logic [RW-1:0] crow_ext;
    assign ccol_ext = CW'(ccol_reg);
    assign crow_ext = RW'(crow_reg);

    // Window bounds from the winner.
    logic [CW+RadiusW:0] lo_c, hi_c;
    logic [RW+RadiusW:0] lo_r, hi_r;
    logic [CW-1:0]       nbc;
    logic [RW-1:0]       nbr;
    logic                take;
    assign take = first_reg || (cur_dist < best_reg);
    assign nbc  = take ? rcol_reg : bc_reg;
    assign nbr  = take ? rrow_reg : br_reg;
    assign lo_c = (CW+RadiusW+1)'(nbc) - (CW+RadiusW+1)'(radius_reg);
    assign hi_c = (CW+RadiusW+1)'(nbc) + (CW+RadiusW+1)'(radius_reg);
    assign lo_r = (RW+RadiusW+1)'(nbr) - (RW+RadiusW+1)'(radius_reg);
    assign hi_r = (RW+RadiusW+1)'(nbr) + (RW+RadiusW+1)'(radius_reg);

    // Memory port control.
    always_comb
    begin
        w_we = 1'b0;
        w_addr = cell_addr(col_reg, row_reg);
        w_wdata = moved;
        l_we = 1'b0;
        l_addr = cell_addr(ccol_ext, crow_ext);
        l_wdata = label_reg;
        case (state_reg)
            S_CLEAR: begin
                l_we = 1'b1;
                l_addr = clr_reg[AddrW-1:0];
                l_wdata = '0;
            end
            S_ACC: begin
                // A train transaction reads the first cell of the scan here.
                if (mode_reg != MODE_TRAIN) begin
                    if (mode_reg == MODE_LOAD && cell_in_grid) begin
                        w_we = 1'b1;
                    end
                    w_addr = cell_addr(ccol_ext, crow_ext);
                end
                w_wdata = {v_reg[3], v_reg[2], v_reg[1], v_reg[0]};
            end
            S_RDWAIT: begin
                w_addr = cell_addr(ccol_ext, crow_ext);
            end
            S_LAST: begin
                l_we = 1'b1;
                l_addr = cell_addr(nbc, nbr);
            end
            S_UPWR: begin
                w_we = 1'b1;
                w_addr = cell_addr(rcol_reg, rrow_reg);
            end
            default: begin
            end
        endcase
    end

    // Sequencer and registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else begin
            // The output register is loaded when free or being taken.
            if (state_reg == S_OUT && (!ov_reg || !out_stall)) begin
                ov_reg <= 1'b1;
            end
            else if (ov_reg && !out_stall) begin
                ov_reg <= 1'b0;
            end
            case (state_reg)
                S_CLEAR: begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == LastCell) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_valid) begin
                        mode_reg   <= mode;
                        v_reg[0]   <= feature_0;
                        v_reg[1]   <= feature_1;
                        v_reg[2]   <= feature_2;
                        v_reg[3]   <= feature_3;
                        alpha_reg  <= learn_rate;
                        radius_reg <= radius;
                        label_reg  <= class_label;
                        ccol_reg   <= cell_col;
                        crow_reg   <= cell_row;
                        col_reg    <= '0;
                        row_reg    <= '0;
                        first_reg  <= 1'b1;
                        state_reg  <= S_ACC;
                    end
                end
                S_ACC: begin
                    res_col_reg  <= '0;
                    res_row_reg  <= '0;
                    res_dist_reg <= '0;
                    res_lab_reg  <= '0;
                    res_w_reg    <= '0;
                    if (mode_reg == MODE_TRAIN) begin
                        rcol_reg <= col_reg;
                        rrow_reg <= row_reg;
                        if (row_reg == LastRow) begin
                            row_reg <= '0;
                            col_reg <= col_reg + 1'b1;
                        end
                        else begin
                            row_reg <= row_reg + 1'b1;
                        end
                        state_reg <= (row_reg == LastRow && col_reg == LastCol) ?
                                     S_LAST : S_SCAN;
                    end
                    else if (mode_reg == MODE_READ && cell_in_grid) begin
                        state_reg <= S_RDWAIT;
                    end
                    else begin
                        state_reg <= S_OUT;
                    end
                end
                S_SCAN: begin
                    first_reg <= 1'b0;
                    if (take) begin
                        best_reg <= cur_dist;
                        bc_reg <= rcol_reg;
                        br_reg <= rrow_reg;
                    end
                    rcol_reg <= col_reg;
                    rrow_reg <= row_reg;
                    if (row_reg == LastRow) begin
                        row_reg <= '0;
                        col_reg <= col_reg + 1'b1;
                    end
                    else begin
                        row_reg <= row_reg + 1'b1;
                    end
                    if (row_reg == LastRow && col_reg == LastCol) begin
                        state_reg <= S_LAST;
                    end
                end
                S_LAST: begin
                    res_col_reg  <= CoordW'(nbc);
                    res_row_reg  <= CoordW'(nbr);
                    res_dist_reg <= take ? cur_dist : best_reg;
                    c1_reg <= (hi_c > (CW+RadiusW+1)'(LastCol)) ? LastCol : CW'(hi_c);
                    r0_reg <= lo_r[RW+RadiusW] ? '0 : RW'(lo_r);
                    r1_reg <= (hi_r > (RW+RadiusW+1)'(LastRow)) ? LastRow : RW'(hi_r);
                    col_reg <= lo_c[CW+RadiusW] ? '0 : CW'(lo_c);
                    row_reg <= lo_r[RW+RadiusW] ? '0 : RW'(lo_r);
                    state_reg <= S_UPRD;
                end
                S_UPRD: begin
                    rcol_reg <= col_reg;
                    rrow_reg <= row_reg;
                    if (row_reg == r1_reg) begin
                        row_reg <= r0_reg;
                        col_reg <= col_reg + 1'b1;
                    end
                    else begin
                        row_reg <= row_reg + 1'b1;
                    end
                    state_reg <= S_UPWR;
                end
                S_UPWR: begin
                    if (rrow_reg == r1_reg && rcol_reg == c1_reg) begin
                        state_reg <= S_OUT;
                    end
                    else begin
                        state_reg <= S_UPRD;
                    end
                end
                S_RDWAIT: begin
                    state_reg <= S_RDOUT;
                end
                S_RDOUT: begin
                    res_lab_reg <= l_rdata;
                    res_w_reg   <= w_rdata;
                    state_reg   <= S_OUT;
                end
                S_OUT: begin
                    if (!ov_reg || !out_stall) begin
                        ocol_reg  <= res_col_reg;
                        orow_reg  <= res_row_reg;
                        odist_reg <= res_dist_reg;
                        olab_reg  <= res_lab_reg;
                        ow_reg    <= res_w_reg;
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // The read address of a weight word is held in S_RDWAIT.
    assign in_stall     = (state_reg != S_IDLE);
    assign out_valid    = ov_reg;
    assign win_col      = ocol_reg;
    assign win_row      = orow_reg;
    assign win_distance = odist_reg;
    assign cell_label   = olab_reg;
    assign weight_0     = ow_reg[0*FeatW +: FeatW];
    assign weight_1     = ow_reg[1*FeatW +: FeatW];
    assign weight_2     = ow_reg[2*FeatW +: FeatW];
    assign weight_3     = ow_reg[3*FeatW +: FeatW];

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Map search and update unit testbench
// Loads every neuron and then runs directed and random train, load and read
// transactions against a behavioural copy of the map. Results are checked
// field by field in order. Both handshakes see random gaps and stalls.
// ----------------------------------------------------------------------------
module testbench;

    import som_pkg::*;

    localparam int Cols  = 16;
    localparam int Rows  = 16;
    localparam int Cells = Cols * Rows;

    typedef struct packed {
        logic [CoordW-1:0] col;
        logic [CoordW-1:0] row;
        logic [DistW-1:0]  distance;
        logic [LabelW-1:0] label;
        logic [FeatW-1:0]  w0;
        logic [FeatW-1:0]  w1;
        logic [FeatW-1:0]  w2;
        logic [FeatW-1:0]  w3;
    } som_result_t;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic [ModeW-1:0]    mode;
    logic [FeatW-1:0]    feature_0;
    logic [FeatW-1:0]    feature_1;
    logic [FeatW-1:0]    feature_2;
    logic [FeatW-1:0]    feature_3;
    logic [FeatW-1:0]    learn_rate;
    logic [RadiusW-1:0]  radius;
    logic [LabelW-1:0]   class_label;
    logic [CoordW-1:0]   cell_col;
    logic [CoordW-1:0]   cell_row;
    logic                out_valid;
    logic                out_stall;
    logic [CoordW-1:0]   win_col;
    logic [CoordW-1:0]   win_row;
    logic [DistW-1:0]    win_distance;
    logic [LabelW-1:0]   cell_label;
    logic [FeatW-1:0]    weight_0;
    logic [FeatW-1:0]    weight_1;
    logic [FeatW-1:0]    weight_2;
    logic [FeatW-1:0]    weight_3;

    // Behavioural copy of the map
    logic [FeatW-1:0]    map_weights [Cells][NumFeatures];
    logic [LabelW-1:0]   map_labels [Cells];
    som_result_t         expected_results [$];
    int                  error_count;
    int                  burst_left;

    som_bmu_search_and_update_unit #(
        .GRID_COLS (Cols),
        .GRID_ROWS (Rows)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .mode         (mode),
        .feature_0    (feature_0),
        .feature_1    (feature_1),
        .feature_2    (feature_2),
        .feature_3    (feature_3),
        .learn_rate   (learn_rate),
        .radius       (radius),
        .class_label  (class_label),
        .cell_col     (cell_col),
        .cell_row     (cell_row),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .win_col      (win_col),
        .win_row      (win_row),
        .win_distance (win_distance),
        .cell_label   (cell_label),
        .weight_0     (weight_0),
        .weight_1     (weight_1),
        .weight_2     (weight_2),
        .weight_3     (weight_3)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Global time limit
    initial
    begin
        #200ms;
        $display("FAILED: results differ");
        $finish;
    end

    // One weight moved towards the sample, floored and saturated.
    function automatic logic [FeatW-1:0] pull_weight(logic [FeatW-1:0] w,
                                                     logic [FeatW-1:0] v,
                                                     logic [FeatW-1:0] alpha);
        longint prod;
        longint nw;
        if (v >= w)
        begin
            prod = longint'(alpha) * longint'(v - w);
            nw   = longint'(w) + (prod >>> 16);
        end
        else
        begin
            prod = longint'(alpha) * longint'(w - v);
            nw   = longint'(w) - ((prod + 65535) >>> 16);
        end
        if (nw < 0)
            nw = 0;
        if (nw > 65535)
            nw = 65535;
        return nw[FeatW-1:0];
    endfunction

    // Applies one accepted transaction to the map and returns its result.
    function automatic som_result_t apply_transaction(logic [ModeW-1:0] md,
                                                      logic [FeatW-1:0] v [NumFeatures],
                                                      logic [FeatW-1:0] alpha,
                                                      logic [RadiusW-1:0] rad,
                                                      logic [LabelW-1:0] lbl,
                                                      logic [CoordW-1:0] ccol,
                                                      logic [CoordW-1:0] crow);
        som_result_t res;
        longint      best;
        longint      cell_dist;
        longint      diff;
        int          best_col;
        int          best_row;
        int          idx;
        int          rad_i;
        int          c_lo;
        int          c_hi;
        int          r_lo;
        int          r_hi;
        res = '0;
        if (md == MODE_TRAIN)
        begin
            best     = -1;
            best_col = 0;
            best_row = 0;
            // Column-major scan, first strict minimum wins
            for (int c = 0; c < Cols; c++)
                for (int r = 0; r < Rows; r++)
                begin
                    cell_dist = 0;
                    for (int k = 0; k < NumFeatures; k++)
                    begin
                        diff = longint'(v[k]) - longint'(map_weights[c*Rows+r][k]);
                        cell_dist += diff * diff;
                    end
                    if (best < 0 || cell_dist < best)
                    begin
                        best     = cell_dist;
                        best_col = c;
                        best_row = r;
                    end
                end
            map_labels[best_col*Rows+best_row] = lbl;
            rad_i = int'(rad);
            c_lo = (best_col - rad_i < 0) ? 0 : best_col - rad_i;
            c_hi = (best_col + rad_i > Cols - 1) ? Cols - 1 : best_col + rad_i;
            r_lo = (best_row - rad_i < 0) ? 0 : best_row - rad_i;
            r_hi = (best_row + rad_i > Rows - 1) ? Rows - 1 : best_row + rad_i;
            for (int c = c_lo; c <= c_hi; c++)
                for (int r = r_lo; r <= r_hi; r++)
                    for (int k = 0; k < NumFeatures; k++)
                        map_weights[c*Rows+r][k] =
                            pull_weight(map_weights[c*Rows+r][k], v[k], alpha);
            res.col      = best_col[CoordW-1:0];
            res.row      = best_row[CoordW-1:0];
            res.distance = best[DistW-1:0];
        end
        else if (md == MODE_LOAD)
        begin
            idx = ccol * Rows + crow;
            for (int k = 0; k < NumFeatures; k++)
                map_weights[idx][k] = v[k];
        end
        else if (md == MODE_READ)
        begin
            idx       = ccol * Rows + crow;
            res.label = map_labels[idx];
            res.w0    = map_weights[idx][0];
            res.w1    = map_weights[idx][1];
            res.w2    = map_weights[idx][2];
            res.w3    = map_weights[idx][3];
        end
        return res;
    endfunction

    // Sends one transaction in bursts with random gaps, predicting on acceptance.
    task automatic send_transaction(logic [ModeW-1:0] md,
                                    logic [FeatW-1:0] f0, logic [FeatW-1:0] f1,
                                    logic [FeatW-1:0] f2, logic [FeatW-1:0] f3,
                                    logic [FeatW-1:0] alpha, logic [RadiusW-1:0] rad,
                                    logic [LabelW-1:0] lbl,
                                    logic [CoordW-1:0] ccol, logic [CoordW-1:0] crow);
        logic [FeatW-1:0] v [NumFeatures];
        int               gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            repeat (gap)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
            end
        end
        burst_left--;
        @(negedge clk);
        in_valid    <= 1'b1;
        mode        <= md;
        feature_0   <= f0;
        feature_1   <= f1;
        feature_2   <= f2;
        feature_3   <= f3;
        learn_rate  <= alpha;
        radius      <= rad;
        class_label <= lbl;
        cell_col    <= ccol;
        cell_row    <= crow;
        do
            @(posedge clk);
        while (in_stall);
        v = '{f0, f1, f2, f3};
        expected_results.push_back(apply_transaction(md, v, alpha, rad, lbl, ccol, crow));
    endtask

    task automatic go_idle();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        go_idle();
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [FeatW-1:0] random_feature();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return FeatW'($urandom_range(0, 15));
            default: return FeatW'($urandom);
        endcase
    endfunction

    // Every neuron gets weights before any train or read touches it.
    task automatic test_load_all();
        for (int c = 0; c < Cols; c++)
            for (int r = 0; r < Rows; r++)
                send_transaction(MODE_LOAD, random_feature(), random_feature(),
                                 random_feature(), random_feature(), FeatW'($urandom),
                                 RadiusW'($urandom), LabelW'($urandom),
                                 CoordW'(c), CoordW'(r));
    endtask

    // Field extremes, every mode, ties and window clipping.
    task automatic test_directed();
        // Two equal neurons: the one scanned first must win with distance zero
        send_transaction(MODE_LOAD, 16'h1234, 16'h1234, 16'h1234, 16'h1234, 0, 0, 0, 3, 5);
        send_transaction(MODE_LOAD, 16'h1234, 16'h1234, 16'h1234, 16'h1234, 0, 0, 0, 9, 2);
        send_transaction(MODE_TRAIN, 16'h1234, 16'h1234, 16'h1234, 16'h1234, 16'hffff,
                         0, 2'd3, 0, 0);
        send_transaction(MODE_READ, 0, 0, 0, 0, 0, 0, 0, 3, 5);
        // Corner neurons at the extremes, trained with the widest window
        send_transaction(MODE_LOAD, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 0, 0, 0, 0, 0);
        send_transaction(MODE_LOAD, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 0, 0, 0, 15, 15);
        send_transaction(MODE_TRAIN, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
                         4'd15, 2'd1, 0, 0);
        send_transaction(MODE_TRAIN, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h8000,
                         4'd15, 2'd2, 15, 15);
        send_transaction(MODE_TRAIN, 16'hffff, 16'h0000, 16'hffff, 16'h0000, 16'h0000,
                         4'd1, 2'd0, 0, 0);
        send_transaction(MODE_TRAIN, 16'h5555, 16'haaaa, 16'h00ff, 16'hff00, 16'h0001,
                         4'd3, 2'd1, 0, 0);
        send_transaction(MODE_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_transaction(MODE_READ, 0, 0, 0, 0, 0, 0, 0, 15, 15);
        send_transaction(MODE_READ, 0, 0, 0, 0, 0, 0, 0, 0, 15);
        send_transaction(MODE_READ, 0, 0, 0, 0, 0, 0, 0, 15, 0);
        // Unused mode changes nothing and answers zeros
        send_transaction(2'd3, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
                         4'd15, 2'd3, 15, 15);
        send_transaction(MODE_READ, 0, 0, 0, 0, 0, 0, 0, 15, 15);
    endtask

    // Random mix of transactions, mostly small training windows.
    task automatic test_random(int count);
        int               sel;
        logic [ModeW-1:0] md;
        logic [RadiusW-1:0] rad;
        for (int n = 0; n < count; n++)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 40)
                md = MODE_TRAIN;
            else if (sel < 62)
                md = MODE_LOAD;
            else if (sel < 92)
                md = MODE_READ;
            else
                md = 2'd3;
            rad = ($urandom_range(0, 9) == 0) ? RadiusW'($urandom) : RadiusW'($urandom_range(0, 3));
            send_transaction(md, random_feature(), random_feature(), random_feature(),
                             random_feature(), FeatW'($urandom), rad, LabelW'($urandom),
                             CoordW'($urandom), CoordW'($urandom));
            // Hold off now and then until every result is back
            if (n % 300 == 150)
                wait_drained();
        end
    endtask

    // Receiver stall pattern: phases of no, light and heavy stalling.
    initial
    begin
        int phase_len;
        int kind;
        out_stall = 1'b0;
        forever
        begin
            phase_len = $urandom_range(20, 200);
            kind      = $urandom_range(0, 2);
            repeat (phase_len)
            begin
                @(negedge clk);
                if (kind == 0)
                    out_stall <= 1'b0;
                else if (kind == 1)
                    out_stall <= ($urandom_range(0, 3) == 0);
                else
                    out_stall <= ($urandom_range(0, 1) == 0);
            end
        end
    end

    // Result checker
    always @(posedge clk)
    begin
        som_result_t exp_res;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result transaction with no expectation waiting");
                error_count++;
            end
            else
            begin
                exp_res = expected_results.pop_front();
                if (win_col !== exp_res.col)
                begin
                    $error("win_col expected %0d actual %0d", exp_res.col, win_col);
                    error_count++;
                end
                if (win_row !== exp_res.row)
                begin
                    $error("win_row expected %0d actual %0d", exp_res.row, win_row);
                    error_count++;
                end
                if (win_distance !== exp_res.distance)
                begin
                    $error("win_distance expected %0d actual %0d", exp_res.distance,
                           win_distance);
                    error_count++;
                end
                if (cell_label !== exp_res.label)
                begin
                    $error("cell_label expected %0d actual %0d", exp_res.label, cell_label);
                    error_count++;
                end
                if (weight_0 !== exp_res.w0)
                begin
                    $error("weight_0 expected %h actual %h", exp_res.w0, weight_0);
                    error_count++;
                end
                if (weight_1 !== exp_res.w1)
                begin
                    $error("weight_1 expected %h actual %h", exp_res.w1, weight_1);
                    error_count++;
                end
                if (weight_2 !== exp_res.w2)
                begin
                    $error("weight_2 expected %h actual %h", exp_res.w2, weight_2);
                    error_count++;
                end
                if (weight_3 !== exp_res.w3)
                begin
                    $error("weight_3 expected %h actual %h", exp_res.w3, weight_3);
                    error_count++;
                end
            end
        end
    end

    // Test sequence
    initial
    begin
        int waited;
        error_count = 0;
        burst_left  = 0;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        mode        = MODE_READ;
        feature_0   = '0;
        feature_1   = '0;
        feature_2   = '0;
        feature_3   = '0;
        learn_rate  = '0;
        radius      = '0;
        class_label = '0;
        cell_col    = '0;
        cell_row    = '0;
        for (int i = 0; i < Cells; i++)
        begin
            map_labels[i] = '0;
            for (int k = 0; k < NumFeatures; k++)
                map_weights[i][k] = '0;
        end
        repeat (4)
            @(negedge clk);
        rst_n = 1'b1;

        test_load_all();
        test_directed();
        test_random(1380);
        go_idle();

        // Drain, then give the block time to show any stray result
        waited = 0;
        while (expected_results.size() != 0 && waited < 200000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (1000)
            @(posedge clk);
        if (expected_results.size() != 0)
        begin
            $error("%0d expected results never arrived", expected_results.size());
            error_count++;
        end
        if (error_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

FILE: files.f
rtl/som_pkg.sv
rtl/som_ram.sv
rtl/som_bmu_search_and_update_unit.sv
bench/testbench.sv
